@@ sv/stq_pkg.sv @@
// shared constants, codes and types for the sorted timer expiry queue
package stq_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int COUNT_BITS_DEF  = 32;
    localparam int ID_BITS         = 8;
    localparam int DELAY_BITS      = 24;
    localparam int KIND_BITS       = 2;

    localparam logic CMD_ADD  = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    localparam logic [KIND_BITS-1:0] KIND_ACCEPT = 2'd0;
    localparam logic [KIND_BITS-1:0] KIND_REJECT = 2'd1;
    localparam logic [KIND_BITS-1:0] KIND_EXPIRE = 2'd2;

    typedef struct packed {
        logic ins;
        logic pop;
    } cell_ctrl_t;

endpackage

@@ sv/stq_cell.sv @@
// one queue slot: holds a timer and shifts right on insert, left on pop
module stq_cell
    import stq_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  cell_ctrl_t            ctrl,
    input  logic [COUNT_BITS-1:0] new_deadline,
    input  logic [ID_BITS-1:0]    new_handle,
    input  logic                  prev_after,
    input  logic                  prev_valid,
    input  logic [COUNT_BITS-1:0] prev_deadline,
    input  logic [ID_BITS-1:0]    prev_handle,
    input  logic                  next_valid,
    input  logic [COUNT_BITS-1:0] next_deadline,
    input  logic [ID_BITS-1:0]    next_handle,
    output logic                  after,
    output logic                  valid,
    output logic [COUNT_BITS-1:0] deadline,
    output logic [ID_BITS-1:0]    handle
);

    logic                  valid_reg;
    logic [COUNT_BITS-1:0] deadline_reg;
    logic [ID_BITS-1:0]    handle_reg;

    // slot is at or past the insert point
    assign after    = !valid_reg || (deadline_reg >= new_deadline);
    assign valid    = valid_reg;
    assign deadline = deadline_reg;
    assign handle   = handle_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ctrl.pop)
        begin
            valid_reg <= next_valid;
        end
        else if (ctrl.ins)
        begin
            if (prev_after)
            begin
                valid_reg <= prev_valid;
            end
            else if (after)
            begin
                valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.pop)
        begin
            deadline_reg <= next_deadline;
            handle_reg   <= next_handle;
        end
        else if (ctrl.ins)
        begin
            if (prev_after)
            begin
                deadline_reg <= prev_deadline;
                handle_reg   <= prev_handle;
            end
            else if (after)
            begin
                deadline_reg <= new_deadline;
                handle_reg   <= new_handle;
            end
        end
    end

endmodule

@@ sv/sorted_timer_expiry_queue_top.sv @@
// top level: tick counter, command sequencer and the chain of queue slots
//
// channel  dir  tdata                          tuser        tlast
// s_axis   in   timer_id[7:0], delay[31:8]     command[0]   -
// m_axis   out  expired_id[7:0]                kind[1:0]    last
//
// add: take the request and form the deadline in S_IDLE, then insert in S_ADD
// tick: take the request and bump the counter, then pop each due expiry from
//   the head of the slot chain, or return to idle if none is due
// reset clears the counter and all slot valid bits; no clearing pass
// a stalled m_axis holds the sequencer; s_axis is taken only when idle
module sorted_timer_expiry_queue_top
    import stq_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int COUNT_BITS  = COUNT_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [31:0]          s_axis_tdata,   // timer_id, delay
    input  logic                 s_axis_tuser,   // command
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [7:0]           m_axis_tdata,   // expired_id
    output logic [KIND_BITS-1:0] m_axis_tuser,   // kind
    output logic                 m_axis_tlast
);

    localparam int SUM_BITS = ((COUNT_BITS > DELAY_BITS) ? COUNT_BITS : DELAY_BITS) + 1;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    typedef enum logic [1:0] {
        S_IDLE,
        S_ADD,
        S_TICK
    } state_t;

    state_t                 state_reg;
    logic [COUNT_BITS-1:0]  count_reg;
    logic [COUNT_BITS-1:0]  deadline_reg;
    logic [ID_BITS-1:0]     id_reg;
    logic                   m_valid_reg;
    logic [ID_BITS-1:0]     m_id_reg;
    logic [KIND_BITS-1:0]   m_kind_reg;
    logic                   m_last_reg;

    logic [ID_BITS-1:0]     in_id;
    logic [DELAY_BITS-1:0]  in_delay;
    logic [SUM_BITS-1:0]    sum;
    logic [COUNT_BITS-1:0]  deadline_next;
    logic                   accept;
    logic                   slot_free;
    logic                   full;
    logic                   head_due;
    logic                   second_due;
    cell_ctrl_t             ctrl;

    logic                  c_after    [QUEUE_DEPTH];
    logic                  c_valid    [QUEUE_DEPTH];
    logic [COUNT_BITS-1:0] c_deadline [QUEUE_DEPTH];
    logic [ID_BITS-1:0]    c_handle   [QUEUE_DEPTH];

    assign in_id    = s_axis_tdata[ID_BITS-1:0];
    assign in_delay = s_axis_tdata[ID_BITS +: DELAY_BITS];

    // saturating deadline
    assign sum = SUM_BITS'(count_reg) + SUM_BITS'(in_delay);
    assign deadline_next = (sum > SUM_BITS'(COUNT_MAX)) ? COUNT_MAX : sum[COUNT_BITS-1:0];

    assign s_axis_tready = (state_reg == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign slot_free     = !m_valid_reg || m_axis_tready;
    assign full          = c_valid[QUEUE_DEPTH-1];
    assign head_due      = c_valid[0] && (c_deadline[0] <= count_reg);
    assign second_due    = c_valid[1] && (c_deadline[1] <= count_reg);

    always_comb
    begin
        ctrl = '0;
        if (state_reg == S_ADD && slot_free && !full)
        begin
            ctrl.ins = 1'b1;
        end
        if (state_reg == S_TICK && slot_free && head_due)
        begin
            ctrl.pop = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            deadline_reg <= '0;
            id_reg       <= '0;
            m_valid_reg  <= 1'b0;
            m_id_reg     <= '0;
            m_kind_reg   <= KIND_ACCEPT;
            m_last_reg   <= 1'b0;
        end
        else
        begin
            if (m_valid_reg && m_axis_tready)
            begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        id_reg       <= in_id;
                        deadline_reg <= deadline_next;
                        if (s_axis_tuser == CMD_TICK)
                        begin
                            if (count_reg != COUNT_MAX)
                            begin
                                count_reg <= count_reg + 1'b1;
                            end
                            state_reg <= S_TICK;
                        end
                        else
                        begin
                            state_reg <= S_ADD;
                        end
                    end
                end
                S_ADD:
                begin
                    if (slot_free)
                    begin
                        m_valid_reg <= 1'b1;
                        m_id_reg    <= id_reg;
                        m_kind_reg  <= full ? KIND_REJECT : KIND_ACCEPT;
                        m_last_reg  <= 1'b1;
                        state_reg   <= S_IDLE;
                    end
                end
                S_TICK:
                begin
                    if (!head_due)
                    begin
                        state_reg <= S_IDLE;
                    end
                    else if (slot_free)
                    begin
                        m_valid_reg <= 1'b1;
                        m_id_reg    <= c_handle[0];
                        m_kind_reg  <= KIND_EXPIRE;
                        m_last_reg  <= !second_due;
                        if (!second_due)
                        begin
                            state_reg <= S_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_id_reg;
    assign m_axis_tuser  = m_kind_reg;
    assign m_axis_tlast  = m_last_reg;

    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        logic                  p_after;
        logic                  p_valid;
        logic [COUNT_BITS-1:0] p_deadline;
        logic [ID_BITS-1:0]    p_handle;
        logic                  n_valid;
        logic [COUNT_BITS-1:0] n_deadline;
        logic [ID_BITS-1:0]    n_handle;

        if (i == 0)
        begin : g_first
            assign p_after    = 1'b0;
            assign p_valid    = 1'b0;
            assign p_deadline = '0;
            assign p_handle   = '0;
        end
        else
        begin : g_mid
            assign p_after    = c_after[i-1];
            assign p_valid    = c_valid[i-1];
            assign p_deadline = c_deadline[i-1];
            assign p_handle   = c_handle[i-1];
        end

        if (i == QUEUE_DEPTH - 1)
        begin : g_last
            assign n_valid    = 1'b0;
            assign n_deadline = '0;
            assign n_handle   = '0;
        end
        else
        begin : g_inner
            assign n_valid    = c_valid[i+1];
            assign n_deadline = c_deadline[i+1];
            assign n_handle   = c_handle[i+1];
        end

        stq_cell #(
            .COUNT_BITS (COUNT_BITS)
        ) u_cell (
            .clk           (clk),
            .rst_n         (rst_n),
            .ctrl          (ctrl),
            .new_deadline  (deadline_reg),
            .new_handle    (id_reg),
            .prev_after    (p_after),
            .prev_valid    (p_valid),
            .prev_deadline (p_deadline),
            .prev_handle   (p_handle),
            .next_valid    (n_valid),
            .next_deadline (n_deadline),
            .next_handle   (n_handle),
            .after         (c_after[i]),
            .valid         (c_valid[i]),
            .deadline      (c_deadline[i]),
            .handle        (c_handle[i])
        );
    end

endmodule
